@@ hdl/dbd_pkg.sv @@
// shared widths, constants, stage control type and month table for the
// days-between-dates pipeline; no dependencies
package dbd_pkg;

	localparam int DAY_W   = 5;
	localparam int MONTH_W = 4;
	localparam int YEAR_W  = 14;
	localparam int COUNT_W = 22;

	// day of year reaches 366, whole-year days reach about 3.65 million
	localparam int ORD_W   = 9;
	localparam int TOTAL_W = 23;

	localparam int MAX_YEAR  = 9999;
	localparam int MONTHS    = 12;
	localparam int COUNT_MAX = (1 << COUNT_W) - 1;

	// year / 100 as (year * DIV100_MULT) >> DIV100_SHIFT, exact below 43690
	localparam int DIV100_SHIFT = 21;
	localparam int DIV100_MULT  = ((1 << DIV100_SHIFT) + 99) / 100;
	localparam int MULT_W       = 15;
	localparam int PROD_W       = YEAR_W + MULT_W;
	localparam int CENT_W       = PROD_W - DIV100_SHIFT;

	typedef struct packed {
		logic ld_s1;
		logic ld_s2;
		logic ld_s3;
	} stage_ctl_t;

	// days in the months before the given month (1 is January, no leap day)
	function automatic logic [ORD_W-1:0] days_before_month(input logic [MONTH_W-1:0] month);
		logic [ORD_W-1:0] days;
		case (month)
			4'd1:    days = 9'd0;
			4'd2:    days = 9'd31;
			4'd3:    days = 9'd59;
			4'd4:    days = 9'd90;
			4'd5:    days = 9'd120;
			4'd6:    days = 9'd151;
			4'd7:    days = 9'd181;
			4'd8:    days = 9'd212;
			4'd9:    days = 9'd243;
			4'd10:   days = 9'd273;
			4'd11:   days = 9'd304;
			4'd12:   days = 9'd334;
			default: days = 9'd0;
		endcase
		return days;
	endfunction

endpackage

@@ hdl/days_between_dates_top.sv @@
// days between two dates: input transfers pass the stage 1 to 4 registers
// (four register stages) to out_valid; one date pair per cycle unless stalled;
// every stage holds under a stall and empty stages fill while the output waits
// arst_n clears all stage valid bits; payload registers are not reset
// depends on dbd_pkg and dbd_date_path
module days_between_dates_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [dbd_pkg::DAY_W-1:0]       first_day,
	input  logic [dbd_pkg::MONTH_W-1:0]     first_month,
	input  logic [dbd_pkg::YEAR_W-1:0]      first_year,
	input  logic [dbd_pkg::DAY_W-1:0]       second_day,
	input  logic [dbd_pkg::MONTH_W-1:0]     second_month,
	input  logic [dbd_pkg::YEAR_W-1:0]      second_year,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [dbd_pkg::COUNT_W-1:0]     span_days,
	output logic                            reversed
);

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic rdy1, rdy2, rdy3, rdy4;
	logic ld4;
	dbd_pkg::stage_ctl_t ctl;

	// a stage takes new data when it is empty or its contents move on
	always_comb begin
		rdy4      = !valid_s4 || out_ready;
		rdy3      = !valid_s3 || rdy4;
		rdy2      = !valid_s2 || rdy3;
		rdy1      = !valid_s1 || rdy2;
		ctl.ld_s1 = in_valid && rdy1;
		ctl.ld_s2 = valid_s1 && rdy2;
		ctl.ld_s3 = valid_s2 && rdy3;
		ld4       = valid_s3 && rdy4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= in_valid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
			if (rdy4) valid_s4 <= valid_s3;
		end
	end

	logic [dbd_pkg::YEAR_W-1:0]  year1, year2;
	logic [dbd_pkg::ORD_W-1:0]   ord1, ord2;
	logic [dbd_pkg::TOTAL_W-1:0] total1, total2;

	dbd_date_path u_first (
		.clk       (clk),
		.ctl       (ctl),
		.day       (first_day),
		.month     (first_month),
		.year      (first_year),
		.year_out  (year1),
		.ord_out   (ord1),
		.total_out (total1)
	);

	dbd_date_path u_second (
		.clk       (clk),
		.ctl       (ctl),
		.day       (second_day),
		.month     (second_month),
		.year      (second_year),
		.year_out  (year2),
		.ord_out   (ord2),
		.total_out (total2)
	);

	// stage 4: order check, difference, saturation
	logic                        rev;
	logic [dbd_pkg::TOTAL_W-1:0] diff;
	logic [dbd_pkg::COUNT_W-1:0] count;

	logic [dbd_pkg::COUNT_W-1:0] count_s4;
	logic                        reversed_s4;

	always_comb begin
		rev  = (year1 > year2) || (year1 == year2 && ord1 > ord2);
		// in date order the difference never goes negative
		diff = total2 - total1;
		if (rev) begin
			count = '0;
		end else if (diff > dbd_pkg::TOTAL_W'(dbd_pkg::COUNT_MAX)) begin
			count = dbd_pkg::COUNT_W'(dbd_pkg::COUNT_MAX);
		end else begin
			count = diff[dbd_pkg::COUNT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ld4) begin
			count_s4    <= count;
			reversed_s4 <= rev;
		end
	end

	assign in_ready  = rdy1;
	assign out_valid = valid_s4;
	assign span_days = count_s4;
	assign reversed  = reversed_s4;

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> valid_s1)
		else $error("input transfer did not reach stage 1");

	a_stall_holds_s2: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !rdy3 |=> valid_s2)
		else $error("stage 2 item lost during stall");

	a_stall_holds_s3: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && !rdy4 |=> valid_s3 && $stable(total1) && $stable(total2))
		else $error("stage 3 item changed during stall");

	a_reversed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && reversed |-> span_days == '0)
		else $error("reversed result carries a nonzero count");

endmodule

@@ hdl/dbd_date_path.sv @@
// three pipeline stages that turn one date into its day number:
// clamp and divide by 100, leap year and day of year, closed-form total
// depends on dbd_pkg
module dbd_date_path (
	input  logic                            clk,
	input  dbd_pkg::stage_ctl_t             ctl,
	input  logic [dbd_pkg::DAY_W-1:0]       day,
	input  logic [dbd_pkg::MONTH_W-1:0]     month,
	input  logic [dbd_pkg::YEAR_W-1:0]      year,
	output logic [dbd_pkg::YEAR_W-1:0]      year_out,
	output logic [dbd_pkg::ORD_W-1:0]      ord_out,
	output logic [dbd_pkg::TOTAL_W-1:0]    total_out
);

	// stage 1: clamp, reciprocal multiply for year / 100
	logic [dbd_pkg::YEAR_W-1:0]  year_c;
	logic [dbd_pkg::MONTH_W-1:0] month_c;
	logic [dbd_pkg::PROD_W-1:0]  prod;

	logic [dbd_pkg::YEAR_W-1:0]  year_s1;
	logic [dbd_pkg::MONTH_W-1:0] month_s1;
	logic [dbd_pkg::DAY_W-1:0]   day_s1;
	logic [dbd_pkg::CENT_W-1:0]  cent_s1;

	always_comb begin
		if (year == '0) begin
			year_c = dbd_pkg::YEAR_W'(1);
		end else if (32'(year) > dbd_pkg::MAX_YEAR) begin
			year_c = dbd_pkg::YEAR_W'(dbd_pkg::MAX_YEAR);
		end else begin
			year_c = year;
		end
		if (month == '0) begin
			month_c = dbd_pkg::MONTH_W'(1);
		end else if (month > dbd_pkg::MONTH_W'(dbd_pkg::MONTHS)) begin
			month_c = dbd_pkg::MONTH_W'(dbd_pkg::MONTHS);
		end else begin
			month_c = month;
		end
		prod = dbd_pkg::PROD_W'(year_c) * dbd_pkg::PROD_W'(dbd_pkg::DIV100_MULT);
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_s1) begin
			year_s1  <= year_c;
			month_s1 <= month_c;
			day_s1   <= day;
			cent_s1  <= prod[dbd_pkg::PROD_W-1:dbd_pkg::DIV100_SHIFT];
		end
	end

	// stage 2: leap year, (y-1)/100 from y/100, day of year
	logic                        cent_exact;
	logic                        leap;
	logic [dbd_pkg::CENT_W-1:0]  pcent;
	logic [dbd_pkg::ORD_W-1:0]   ord;

	logic [dbd_pkg::YEAR_W-1:0]  year_s2;
	logic [dbd_pkg::YEAR_W-1:0]  pyear_s2;
	logic [dbd_pkg::CENT_W-1:0]  cent_adj_s2;
	logic [dbd_pkg::ORD_W-1:0]   ord_s2;

	always_comb begin
		cent_exact = (year_s1 == dbd_pkg::YEAR_W'(cent_s1) * dbd_pkg::YEAR_W'(100));
		leap       = (year_s1[1:0] == 2'b00) && (!cent_exact || cent_s1[1:0] == 2'b00);
		pcent      = cent_exact ? cent_s1 - dbd_pkg::CENT_W'(1) : cent_s1;
		ord        = dbd_pkg::days_before_month(month_s1) + dbd_pkg::ORD_W'(day_s1)
			+ dbd_pkg::ORD_W'(leap && month_s1 > dbd_pkg::MONTH_W'(2));
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_s2) begin
			year_s2     <= year_s1;
			pyear_s2    <= year_s1 - dbd_pkg::YEAR_W'(1);
			// p/100 - p/400 folded here, always nonnegative
			cent_adj_s2 <= pcent - (pcent >> 2);
			ord_s2      <= ord;
		end
	end

	// stage 3: 365*p + p/4 - p/100 + p/400 + day of year
	logic [dbd_pkg::TOTAL_W-1:0] total;

	logic [dbd_pkg::YEAR_W-1:0]  year_s3;
	logic [dbd_pkg::ORD_W-1:0]   ord_s3;
	logic [dbd_pkg::TOTAL_W-1:0] total_s3;

	always_comb begin
		total = dbd_pkg::TOTAL_W'(pyear_s2) * dbd_pkg::TOTAL_W'(365)
			+ dbd_pkg::TOTAL_W'(pyear_s2 >> 2)
			- dbd_pkg::TOTAL_W'(cent_adj_s2)
			+ dbd_pkg::TOTAL_W'(ord_s2);
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_s3) begin
			year_s3  <= year_s2;
			ord_s3   <= ord_s2;
			total_s3 <= total;
		end
	end

	assign year_out  = year_s3;
	assign ord_out   = ord_s3;
	assign total_out = total_s3;

endmodule

@@ verif/dbd_span_checker.sv @@
// day-count checker: watches both transfers of the days-between-dates block,
// predicts each result from the date pair and compares in order
// depends on dbd_pkg
`timescale 1ns / 1ps

module dbd_span_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic [dbd_pkg::DAY_W-1:0]   first_day,
	input  logic [dbd_pkg::MONTH_W-1:0] first_month,
	input  logic [dbd_pkg::YEAR_W-1:0]  first_year,
	input  logic [dbd_pkg::DAY_W-1:0]   second_day,
	input  logic [dbd_pkg::MONTH_W-1:0] second_month,
	input  logic [dbd_pkg::YEAR_W-1:0]  second_year,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic [dbd_pkg::COUNT_W-1:0] span_days,
	input  logic                        reversed,
	output int                          error_count,
	output int                          pending_count,
	output int                          results_seen,
	output int                          reversed_seen
);

	typedef struct {
		logic [dbd_pkg::COUNT_W-1:0] count;
		logic                        rev;
	} span_t;

	span_t expected_spans[$];

	// days in the months ahead of each month, no leap day
	int unsigned month_start [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

	function automatic int unsigned clip_year(input logic [dbd_pkg::YEAR_W-1:0] y);
		if (y == 0)
			return 1;
		if (y > dbd_pkg::MAX_YEAR)
			return dbd_pkg::MAX_YEAR;
		return 32'(y);
	endfunction

	function automatic int unsigned ordinal_day(input logic [dbd_pkg::DAY_W-1:0] d,
			input logic [dbd_pkg::MONTH_W-1:0] m, input int unsigned yr);
		int unsigned mo;
		int unsigned n;
		mo = (m == 0) ? 1 : (m > dbd_pkg::MONTHS) ? dbd_pkg::MONTHS : 32'(m);
		n = month_start[mo-1] + 32'(d);
		if (mo > 2 && ((yr % 400 == 0) || (yr % 4 == 0 && yr % 100 != 0)))
			n++;
		return n;
	endfunction

	// days in all whole years ahead of year yr
	function automatic longint unsigned elapsed_days(input int unsigned yr);
		longint unsigned p;
		p = yr - 1;
		return 365 * p + p / 4 - p / 100 + p / 400;
	endfunction

	function automatic span_t predict_span(
			input logic [dbd_pkg::DAY_W-1:0] d1, input logic [dbd_pkg::MONTH_W-1:0] m1,
			input logic [dbd_pkg::YEAR_W-1:0] y1, input logic [dbd_pkg::DAY_W-1:0] d2,
			input logic [dbd_pkg::MONTH_W-1:0] m2, input logic [dbd_pkg::YEAR_W-1:0] y2);
		int unsigned     yr1;
		int unsigned     yr2;
		int unsigned     doy1;
		int unsigned     doy2;
		longint unsigned diff;
		span_t           s;
		yr1  = clip_year(y1);
		yr2  = clip_year(y2);
		doy1 = ordinal_day(d1, m1, yr1);
		doy2 = ordinal_day(d2, m2, yr2);
		if (yr1 > yr2 || (yr1 == yr2 && doy1 > doy2)) begin
			s.count = '0;
			s.rev   = 1'b1;
		end else begin
			diff = (elapsed_days(yr2) + doy2) - (elapsed_days(yr1) + doy1);
			if (diff > dbd_pkg::COUNT_MAX)
				diff = dbd_pkg::COUNT_MAX;
			s.count = diff[dbd_pkg::COUNT_W-1:0];
			s.rev   = 1'b0;
		end
		return s;
	endfunction

	always @(posedge clk) begin
		span_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (reversed)
					reversed_seen++;
				if (expected_spans.size() == 0) begin
					$error("unexpected result transfer: span_days %0d reversed %0b",
						span_days, reversed);
					error_count++;
				end else begin
					want = expected_spans.pop_front();
					if (span_days !== want.count) begin
						$error("span_days mismatch: expected %0d, actual %0d",
							want.count, span_days);
						error_count++;
					end
					if (reversed !== want.rev) begin
						$error("reversed mismatch: expected %0b, actual %0b",
							want.rev, reversed);
						error_count++;
					end
				end
			end
			if (in_valid && in_ready)
				expected_spans.push_back(predict_span(first_day, first_month, first_year,
					second_day, second_month, second_year));
			pending_count <= expected_spans.size();
		end
	end

endmodule

@@ verif/days_between_dates_top_tb.sv @@
// testbench top for days_between_dates_top: clock, reset, date-pair stimulus
// and output backpressure; checking is done by dbd_span_checker
// depends on dbd_pkg, days_between_dates_top and dbd_span_checker
`timescale 1ns / 1ps

module days_between_dates_top_tb;

	logic                        clk;
	logic                        arst_n;
	logic                        in_valid;
	logic                        in_ready;
	logic [dbd_pkg::DAY_W-1:0]   first_day;
	logic [dbd_pkg::MONTH_W-1:0] first_month;
	logic [dbd_pkg::YEAR_W-1:0]  first_year;
	logic [dbd_pkg::DAY_W-1:0]   second_day;
	logic [dbd_pkg::MONTH_W-1:0] second_month;
	logic [dbd_pkg::YEAR_W-1:0]  second_year;
	logic                        out_valid;
	logic                        out_ready;
	logic [dbd_pkg::COUNT_W-1:0] span_days;
	logic                        reversed;

	int error_count;
	int pending_count;
	int results_seen;
	int reversed_seen;
	int pairs_sent;
	bit steady_send;

	days_between_dates_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.first_day    (first_day),
		.first_month  (first_month),
		.first_year   (first_year),
		.second_day   (second_day),
		.second_month (second_month),
		.second_year  (second_year),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.span_days    (span_days),
		.reversed     (reversed)
	);

	dbd_span_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.first_day     (first_day),
		.first_month   (first_month),
		.first_year    (first_year),
		.second_day    (second_day),
		.second_month  (second_month),
		.second_year   (second_year),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.span_days     (span_days),
		.reversed      (reversed),
		.error_count   (error_count),
		.pending_count (pending_count),
		.results_seen  (results_seen),
		.reversed_seen (reversed_seen)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("[days_between_dates_top] ERROR");
		$finish;
	end

	// hold the pair until its transfer; in_ready is settled by the falling edge
	task automatic offer_dates(input int unsigned d1, input int unsigned m1,
			input int unsigned y1, input int unsigned d2,
			input int unsigned m2, input int unsigned y2);
		logic taken;
		in_valid     <= 1'b1;
		first_day    <= dbd_pkg::DAY_W'(d1);
		first_month  <= dbd_pkg::MONTH_W'(m1);
		first_year   <= dbd_pkg::YEAR_W'(y1);
		second_day   <= dbd_pkg::DAY_W'(d2);
		second_month <= dbd_pkg::MONTH_W'(m2);
		second_year  <= dbd_pkg::YEAR_W'(y2);
		do begin
			@(negedge clk);
			taken = in_ready;
			@(posedge clk);
		end while (!taken);
		pairs_sent++;
		if (!steady_send && $urandom_range(99) < 6) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending_count != 0);
		@(posedge clk);
	endtask

	task automatic offer_random_pair();
		int unsigned kind;
		int unsigned y1;
		int unsigned y2;
		kind = $urandom_range(99);
		if (kind < 10) begin
			// raw field noise over the full widths
			offer_dates($urandom_range(0, 31), $urandom_range(0, 15), $urandom_range(0, 16383),
				$urandom_range(0, 31), $urandom_range(0, 15), $urandom_range(0, 16383));
		end else begin
			y1 = $urandom_range(1, dbd_pkg::MAX_YEAR);
			if (kind < 25)
				y2 = y1;
			else if (kind < 40) begin
				// around century boundaries, where the leap rule changes
				if ($urandom_range(1))
					y1 = 100 * $urandom_range(1, dbd_pkg::MAX_YEAR / 100 - 1)
						- $urandom_range(0, 2);
				y2 = y1 + $urandom_range(0, 3);
			end else if (kind < 52)
				y2 = $urandom_range(1, y1);
			else
				y2 = $urandom_range(y1, dbd_pkg::MAX_YEAR);
			offer_dates($urandom_range(1, 31), $urandom_range(1, 12), y1,
				$urandom_range(1, 31), $urandom_range(1, 12), y2);
		end
	endtask

	// receiver: random stalls, one long hold-off while the sender keeps going,
	// and a stretch that always accepts
	initial begin
		int unsigned tick;
		tick = 0;
		out_ready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			@(posedge clk);
			tick++;
			if (tick >= 400 && tick < 550)
				out_ready <= 1'b0;
			else if (tick >= 1200 && tick < 1700)
				out_ready <= 1'b1;
			else
				out_ready <= ($urandom_range(99) >= 6);
		end
	end

	initial begin
		pairs_sent   = 0;
		steady_send  = 1'b0;
		arst_n       <= 1'b0;
		in_valid     <= 1'b0;
		first_day    <= '0;
		first_month  <= '0;
		first_year   <= '0;
		second_day   <= '0;
		second_month <= '0;
		second_year  <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		offer_dates(1, 1, 1, 31, 12, dbd_pkg::MAX_YEAR);         // widest span
		offer_dates(15, 6, 2020, 15, 6, 2020);          // same date
		offer_dates(1, 1, 2000, 1, 1, 1999);            // reversed by year
		offer_dates(2, 3, 2020, 1, 3, 2020);            // reversed within a year
		offer_dates(28, 2, 2000, 1, 3, 2000);           // leap by 400
		offer_dates(28, 2, 1900, 1, 3, 1900);           // century, not leap
		offer_dates(28, 2, 2024, 1, 3, 2024);
		offer_dates(28, 2, 2023, 1, 3, 2023);
		offer_dates(0, 3, 2021, 1, 3, 2021);            // day zero
		offer_dates(31, 2, 2021, 1, 3, 2021);           // day past month end
		offer_dates(5, 0, 2000, 5, 1, 2000);            // month zero
		offer_dates(1, 15, 2000, 31, 12, 2000);         // month above twelve
		offer_dates(1, 1, 0, 1, 1, 1);                  // year zero
		offer_dates(1, 1, dbd_pkg::MAX_YEAR, 1, 1, 16383);       // year past the top
		offer_dates(31, 12, dbd_pkg::MAX_YEAR, 1, 1, 1);
		offer_dates(31, 15, 16383, 31, 15, 16383);      // all field bits set
		offer_dates(1, 1, 10000, 31, 12, dbd_pkg::MAX_YEAR);
		offer_dates(0, 0, 0, 0, 0, 0);
		offer_dates(29, 2, 2000, 29, 2, 2400);
		offer_dates(1, 1, 1600, 1, 1, 2000);
		wait_drained();

		for (int i = 0; i < 2000; i++) begin
			steady_send = (i >= 1000 && i < 1400);
			if (i == 700)
				wait_drained();
			offer_random_pair();
		end
		steady_send = 1'b0;

		wait_drained();
		repeat (8) @(posedge clk);
		$display("sent %0d date pairs (directed edge cases, then random and out-of-range fields)",
			pairs_sent);
		$display("checked %0d results, %0d of them reversed", results_seen, reversed_seen);
		if (error_count == 0)
			$display("[days_between_dates_top] OK");
		else
			$display("[days_between_dates_top] ERROR");
		$finish;
	end

endmodule
